// ----- src/sssd_pkg.sv -----
// Shared types, register codes and the glyph table for the signed
// seven-segment digit encoder. No dependencies.
package sssd_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 4;
    localparam int SEG_W   = 7;
    localparam int CFG_W   = 5;
    localparam int CFG_IDX_W = 2;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOT_POSITION = 2'd1;

    // glyph codes beyond the decimal digits
    localparam logic [3:0] GLYPH_MINUS = 4'd10;
    localparam logic [3:0] GLYPH_BLANK = 4'd11;

    // ceil(2^35 / 10): exact quotient for any 32-bit unsigned value
    localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
    localparam int RECIP_SHIFT = 35;

    typedef struct packed {
        logic [POS_W-1:0] last_index;   // index of the sign position
        logic [CFG_W-1:0] dot_position; // index plus one, 0 = none
    } cfg_t;

    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] mag;
        logic               neg;
    } cell_link_t;

    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] position;
        logic [SEG_W-1:0] segments;
        logic             point_lit;
        logic             last;
    } cell_res_t;

    function automatic logic [SEG_W-1:0] glyph_lut(input logic [3:0] code);
        logic [SEG_W-1:0] seg;
        unique case (code)
            4'd0:        seg = 7'h3F;
            4'd1:        seg = 7'h06;
            4'd2:        seg = 7'h5B;
            4'd3:        seg = 7'h4F;
            4'd4:        seg = 7'h66;
            4'd5:        seg = 7'h6D;
            4'd6:        seg = 7'h7D;
            4'd7:        seg = 7'h07;
            4'd8:        seg = 7'h7F;
            4'd9:        seg = 7'h6F;
            GLYPH_MINUS: seg = 7'h40;
            default:     seg = 7'h00;
        endcase
        return seg;
    endfunction

endpackage

// ----- src/sssd_cell.sv -----
// One display position of the digit chain: holds the remaining magnitude,
// emits this position's glyph, hands magnitude / 10 to the next cell.
// Depends on sssd_pkg.
module sssd_cell #(
    parameter int POS = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sssd_pkg::cfg_t      cfg,
    input  sssd_pkg::cell_link_t link_in,
    output sssd_pkg::cell_link_t link_out,
    output sssd_pkg::cell_res_t  res
);
    import sssd_pkg::*;

    localparam logic [POS_W-1:0] MY_POS = POS_W'(POS);

    logic               valid_reg;
    logic [VALUE_W-1:0] mag_reg;
    logic               neg_reg;

    logic [2*VALUE_W-1:0] prod;
    logic [VALUE_W-1:0]   quot;
    logic [VALUE_W-1:0]   rem_full;
    logic [3:0]           glyph;
    logic                 is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= link_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_in.valid)
        begin
            mag_reg <= link_in.mag;
            neg_reg <= link_in.neg;
        end
    end

    // divide by ten through the reciprocal
    assign prod     = {{VALUE_W{1'b0}}, mag_reg} * {{VALUE_W{1'b0}}, RECIP10};
    assign quot     = VALUE_W'(prod >> RECIP_SHIFT);
    assign rem_full = mag_reg - (quot << 3) - (quot << 1);

    assign is_last = (MY_POS == cfg.last_index);

    always_comb
    begin
        if (is_last)
        begin
            glyph = neg_reg ? GLYPH_MINUS : GLYPH_BLANK;
        end
        else
        begin
            glyph = rem_full[3:0];
        end
    end

    assign link_out.valid = valid_reg && !is_last;
    assign link_out.mag   = quot;
    assign link_out.neg   = neg_reg;

    // gated by valid so the top level can OR all cells together
    assign res.valid     = valid_reg;
    assign res.position  = valid_reg ? MY_POS : '0;
    assign res.segments  = valid_reg ? glyph_lut(glyph) : '0;
    assign res.point_lit = valid_reg && (cfg.dot_position == CFG_W'(POS + 1));
    assign res.last      = valid_reg && is_last;

endmodule

// ----- src/signed_seven_segment_digit_encoder.sv -----
// Top level of the signed seven-segment digit encoder: config registers,
// the chain of position cells and the registered result port.
// Depends on sssd_pkg and sssd_cell.
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+----------------------------
//  input   | start, busy, value                        | word taken: start && !busy
//  result  | strobe, position, segments, point_lit,    | word valid for one cycle
//          | last                                      | while strobe is high
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | write: cfg_valid && cfg_ready
//
// An accepted word produces N result words on consecutive cycles, N being
// digit_count saturated to 1..MAX_POSITIONS. The first result passes the
// cell register, then the output register. Each cycle the word moves one
// cell along the chain, one result per cycle; the next word is taken in
// the cycle the current word's sign cell is active, so results of
// successive words follow without gaps.
// Reset clears valid flags and sets config to digit_count 4, no dot; no
// clearing pass. The receiver cannot stall, so strobe never waits.
module signed_seven_segment_digit_encoder #(
    parameter int MAX_POSITIONS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input word
    input  logic                             start,
    output logic                             busy,
    input  logic signed [sssd_pkg::VALUE_W-1:0] value,
    // result word
    output logic                             strobe,
    output logic [sssd_pkg::POS_W-1:0]       position,
    output logic [sssd_pkg::SEG_W-1:0]       segments,
    output logic                             point_lit,
    output logic                             last,
    // config writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sssd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sssd_pkg::CFG_W-1:0]       cfg_data
);
    import sssd_pkg::*;

    localparam logic [CFG_W-1:0] MAX_CNT = CFG_W'(MAX_POSITIONS);

    logic [CFG_W-1:0] digit_count_reg;
    logic [CFG_W-1:0] dot_position_reg;

    logic [CFG_W-1:0] count_eff;
    cfg_t             cfg;

    cell_link_t link [MAX_POSITIONS+1];
    cell_res_t  res  [MAX_POSITIONS];
    cell_res_t  res_any;

    logic [MAX_POSITIONS-1:0] cell_valid;
    logic [MAX_POSITIONS-1:0] cell_busy;
    logic                     accept;
    logic [VALUE_W-1:0]       raw;

    logic             strobe_reg;
    logic [POS_W-1:0] position_reg;
    logic [SEG_W-1:0] segments_reg;
    logic             point_lit_reg;
    logic             last_reg;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_count_reg  <= 5'd4;
            dot_position_reg <= 5'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DIGIT_COUNT:  digit_count_reg  <= cfg_data;
                REG_DOT_POSITION: dot_position_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // saturate the position count to 1..MAX_POSITIONS
    always_comb
    begin
        if (digit_count_reg == '0)
        begin
            count_eff = CFG_W'(1);
        end
        else if (digit_count_reg > MAX_CNT)
        begin
            count_eff = MAX_CNT;
        end
        else
        begin
            count_eff = digit_count_reg;
        end
    end

    assign cfg.last_index   = POS_W'(count_eff - CFG_W'(1));
    assign cfg.dot_position = dot_position_reg;

    // ---------------- input side ----------------
    // Only one word lives in the chain; a new one may enter when the active
    // cell is the sign cell (or the chain is empty).
    assign busy   = |cell_busy;
    assign accept = start && !busy;
    assign raw    = value;

    assign link[0].valid = accept;
    assign link[0].neg   = raw[VALUE_W-1];
    // 0 - raw also yields 2^31 for the most negative input
    assign link[0].mag   = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;

    // ---------------- cell chain ----------------
    for (genvar i = 0; i < MAX_POSITIONS; i++)
    begin : g_cell
        sssd_cell #(
            .POS (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cfg      (cfg),
            .link_in  (link[i]),
            .link_out (link[i+1]),
            .res      (res[i])
        );
        assign cell_valid[i] = res[i].valid;
        assign cell_busy[i]  = res[i].valid && !res[i].last;
    end

    // cells gate their results by valid, at most one is active
    always_comb
    begin
        res_any = '0;
        for (int i = 0; i < MAX_POSITIONS; i++)
        begin
            res_any = res_any | res[i];
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= res_any.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        position_reg  <= res_any.position;
        segments_reg  <= res_any.segments;
        point_lit_reg <= res_any.point_lit;
        last_reg      <= res_any.last;
    end

    assign strobe    = strobe_reg;
    assign position  = position_reg;
    assign segments  = segments_reg;
    assign point_lit = point_lit_reg;
    assign last      = last_reg;

    // ---------------- assertions ----------------
    a_one_cell: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cell_valid))
        else $error("more than one chain cell active");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> cell_valid[0])
        else $error("accepted word did not reach the first cell");

    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |=> strobe)
        else $error("gap inside the results of one word");

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (res_any.valid && res_any.last) |-> (res_any.position == cfg.last_index))
        else $error("sign position emitted at the wrong index");

endmodule
